// ===== rtl/core/cvl_pkg.sv =====
// shared types and codes for the compacting value list
package cvl_pkg;

    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // operation carried in tuser
    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SWEEP  = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic append;
        logic search;
        logic sweep;
        logic commit;
    } t_cell_ctl;

endpackage

// ===== rtl/core/cvl_cell.sv =====
// one list cell: holds an entry, compares it and passes the hit mark on
module cvl_cell #(
    parameter int IDX    = 0,
    parameter int FILL_W = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cvl_pkg::t_cell_ctl            i_ctl,
    input  logic [FILL_W-1:0]             i_fill,
    input  logic [cvl_pkg::VALUE_W-1:0]   i_value,
    input  logic                          i_seen_prev,
    input  logic [cvl_pkg::VALUE_W-1:0]   i_next_val,
    output logic [cvl_pkg::VALUE_W-1:0]   o_val,
    output logic                          o_seen
);

    localparam logic [FILL_W-1:0] MY_IDX = FILL_W'(IDX);

    logic [cvl_pkg::VALUE_W-1:0] r_val;
    logic                        r_match;
    logic                        r_seen;
    logic                        w_valid;

    assign w_valid = (i_fill > MY_IDX);

    // entry payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.append && (i_fill == MY_IDX)) begin
            r_val <= i_value;
        end else if (i_ctl.commit && r_seen) begin
            r_val <= i_next_val;
        end
    end

    // hit mark ripples one cell per cycle toward the tail
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
            r_seen  <= 1'b0;
        end else if (i_ctl.search) begin
            r_match <= w_valid && (r_val == i_value);
            r_seen  <= 1'b0;
        end else if (i_ctl.sweep) begin
            r_seen  <= i_seen_prev | r_match;
        end
    end

    assign o_val  = r_val;
    assign o_seen = r_seen;

endmodule

// ===== rtl/core/compacting_value_list.sv =====
// top level of the compacting value list
//
// ordered list of signed 32-bit values, up to DEPTH entries packed from the head
// input beat: tuser[0] = func (0 add, 1 remove), tdata = value
// output beat: one per input beat, tdata = status and resulting count
// an add appends at the tail; on a full list it is dropped with status full
// a remove deletes the first entry equal to the value and closes the gap
//
// an add shows its result in the cycle after it is accepted
// a remove compares every cell at once when it is accepted, then ripples the
// hit mark down the row of cells in the sweep state, then shifts the later
// entries toward the head in the commit state
// one item is in flight at a time; s_tready is high only when idle and the
// output register is empty, so a stalled receiver holds off the next beat
// the next beat can be taken only once the result beat has been taken
// reset clears the fill count and the sequencer; entries need no clearing
// since only cells below the fill count are ever compared
module compacting_value_list #(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    input  logic [0:0]  i_s_tuser,   // [0] func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // [1:0] status, [8:2] count, [15:9] zero
);

    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int CNT_W  = $clog2(DEPTH);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);
    localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(DEPTH - 1);

    cvl_pkg::t_state    r_state, n_state;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    logic [cvl_pkg::STATUS_W-1:0] r_status, n_status;
    logic [cvl_pkg::COUNT_W-1:0]  r_count, n_count;

    cvl_pkg::t_cell_ctl w_ctl;
    logic               w_accept;
    logic               w_full;
    logic               w_found;

    logic [cvl_pkg::VALUE_W-1:0] w_val  [DEPTH];
    logic                        w_seen [DEPTH];

    assign o_s_tready = (r_state == cvl_pkg::S_IDLE) && !r_out_valid;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_full     = (r_fill == FULL_FILL);
    // after the full sweep the tail cell holds the or of every hit
    assign w_found    = w_seen[DEPTH-1];

    always_comb begin
        w_ctl.append = w_accept && (i_s_tuser[0] == cvl_pkg::FUNC_ADD) && !w_full;
        w_ctl.search = w_accept && (i_s_tuser[0] == cvl_pkg::FUNC_REMOVE);
        w_ctl.sweep  = (r_state == cvl_pkg::S_SWEEP);
        w_ctl.commit = (r_state == cvl_pkg::S_COMMIT);
    end

    // row of cells, each handing its entry and hit mark to its neighbor
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                        w_prev;
        logic [cvl_pkg::VALUE_W-1:0] w_next;
        if (g == 0) begin : g_head
            assign w_prev = 1'b0;
        end else begin : g_body
            assign w_prev = w_seen[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_next = w_val[g];
        end else begin : g_inner
            assign w_next = w_val[g+1];
        end
        cvl_cell #(
            .IDX    (g),
            .FILL_W (FILL_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_fill      (r_fill),
            .i_value     (i_s_tdata),
            .i_seen_prev (w_prev),
            .i_next_val  (w_next),
            .o_val       (w_val[g]),
            .o_seen      (w_seen[g])
        );
    end

    // sequencer and result register
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_m_tready;
        n_status    = r_status;
        n_count     = r_count;
        case (r_state)
            cvl_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_s_tuser[0] == cvl_pkg::FUNC_ADD) begin
                        n_out_valid = 1'b1;
                        if (w_full) begin
                            n_status = cvl_pkg::ST_FULL;
                        end else begin
                            n_status = cvl_pkg::ST_OK;
                            n_fill   = r_fill + 1'b1;
                        end
                        n_count = cvl_pkg::COUNT_W'(n_fill);
                    end else begin
                        n_state = cvl_pkg::S_SWEEP;
                        n_cnt   = '0;
                    end
                end
            end
            cvl_pkg::S_SWEEP: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_CNT) begin
                    n_state = cvl_pkg::S_COMMIT;
                end
            end
            cvl_pkg::S_COMMIT: begin
                n_state     = cvl_pkg::S_IDLE;
                n_out_valid = 1'b1;
                if (w_found) begin
                    n_status = cvl_pkg::ST_OK;
                    n_fill   = r_fill - 1'b1;
                end else begin
                    n_status = cvl_pkg::ST_NOT_FOUND;
                end
                n_count = cvl_pkg::COUNT_W'(n_fill);
            end
            default: begin
                n_state = cvl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cvl_pkg::S_IDLE;
            r_fill      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_count  <= n_count;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_count, r_status};

endmodule

// ===== rtl/core/cvl_checker.sv =====
// port-level checks for the compacting value list, bound to the top level
module cvl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [0:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata
);

    // a held result keeps its data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // one item in flight: no input beat while a result waits
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("input ready while result pending");

    // an add answers in the next cycle
    a_add_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser[0] == cvl_pkg::FUNC_ADD) |=> o_m_tvalid)
        else $error("add result late");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[1:0] == cvl_pkg::ST_OK)
                    || (o_m_tdata[1:0] == cvl_pkg::ST_NOT_FOUND)
                    || (o_m_tdata[1:0] == cvl_pkg::ST_FULL))
        else $error("undefined status code");

endmodule

bind compacting_value_list cvl_checker u_cvl_checker (.*);
